[rtl/core/isc_pkg.sv]
// shared types and constants for the insertion sorter with counts
// no dependencies; every other file imports it

package isc_pkg;

  localparam int ISC_SLOTS   = 64;
  localparam int VALUE_W     = 32;
  localparam int COMPARE_W   = 11;
  localparam int MOVE_W      = 12;
  localparam int COUNTER_W   = 12;
  localparam int GROUP_BITS  = 8;

  // what a cell shows to its two neighbors
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      gt;
  } cell_link_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_WAIT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

[rtl/core/isc_if.sv]
// stream interfaces for the sorter: input word and result word channels
// depends on isc_pkg

interface isc_in_if
  import isc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface isc_out_if
  import isc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      final_result;
  logic [COMPARE_W-1:0]      compare_total;
  logic [MOVE_W-1:0]         move_total;
  logic                      overflowed;

  modport source (output valid, output sorted_value, output final_result,
                  output compare_total, output move_total, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_result,
                  input compare_total, input move_total, input overflowed,
                  output ready);
endinterface

[rtl/core/isc_cell.sv]
// one slot of the insertion chain: holds a value and its valid bit
// depends on isc_pkg

module isc_cell
  import isc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] sample,
  input  cell_link_t                prev_link,
  input  cell_link_t                next_link,
  output cell_link_t                link
);

  logic signed [VALUE_W-1:0] value;
  logic                      valid;
  logic                      gt;
  logic                      take;

  assign gt   = valid && (value > sample);
  // shifted up by a smaller new value, or the first empty slot
  assign take = gt || (!valid && prev_link.valid);

  always_ff @(posedge clk) begin
    if (ctrl.ins && take) begin
      value <= prev_link.gt ? prev_link.value : sample;
    end else if (ctrl.pop) begin
      value <= next_link.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && take) begin
      valid <= 1'b1;
    end else if (ctrl.pop) begin
      valid <= next_link.valid;
    end
  end

  assign link = '{value: value, valid: valid, gt: gt};

endmodule

[rtl/core/isc_popcount.sv]
// two-stage registered count of the cells that shift on an insert
// depends on isc_pkg

module isc_popcount
  import isc_pkg::*;
#(
  parameter int SLOTS = ISC_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [SLOTS-1:0]           gt_vec,
  output logic                       busy,
  output logic                       sum_valid,
  output logic [$clog2(SLOTS+1)-1:0] sum
);

  localparam int CW     = $clog2(SLOTS + 1);
  localparam int GROUPS = (SLOTS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW     = $clog2(GROUP_BITS + 1);

  logic [GW-1:0] grp_next [GROUPS];
  logic [GW-1:0] grp      [GROUPS];
  logic          grp_valid;
  logic [CW-1:0] sum_next;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        if (g * GROUP_BITS + b < SLOTS) begin
          grp_next[g] = grp_next[g] + GW'(gt_vec[g * GROUP_BITS + b]);
        end
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_next = sum_next + CW'(grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
    sum <= sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      grp_valid <= in_valid;
      sum_valid <= grp_valid;
    end
  end

  assign busy = grp_valid || sum_valid;

endmodule

[rtl/core/insertion_sorter_with_counts_unit.sv]
// insertion sorter with comparison and move counts, top level
// depends on isc_pkg, isc_if, isc_cell, isc_popcount
//
// feed channel: one signed 32-bit word per accepted item; final_item marks
// the last word of a set. result channel: on a final word the held set comes
// out in ascending order, one word per cycle while the receiver is ready,
// each carrying the set's compare and move totals and the overflow flag.
// inserts run through a chain of SLOTS cells that compare against the new
// word and shift in the same cycle, so one word is taken per cycle while a
// set fills. the shift counts go through a two-stage registered popcount,
// so after a final word the block waits for the totals and then loads the
// first result into the output register. feed is not ready from the final
// word until the last result has been loaded into the output register.
// words beyond SLOTS are dropped and set overflowed. a stalled receiver
// holds the output word and the chain. reset empties the chain and clears
// the held count, the compare counter and the overflow flag.

module insertion_sorter_with_counts_unit
  import isc_pkg::*;
#(
  parameter int SLOTS = ISC_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  isc_in_if.sink      feed,
  isc_out_if.source   result
);

  localparam int CW = $clog2(SLOTS + 1);

  state_t             st;
  logic [CW-1:0]      held;
  logic [COUNTER_W-1:0] compare_counter;
  logic [COUNTER_W-1:0] move_hold;
  logic               drop_flag;
  logic               full;
  logic               feed_fire;
  logic               load;
  cell_ctrl_t         ctrl;
  cell_link_t         links [SLOTS];
  logic [SLOTS-1:0]   gt_vec;
  logic               pc_busy;
  logic               pc_valid;
  logic [CW-1:0]      pc_sum;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_final;
  logic [COMPARE_W-1:0]      out_compare;
  logic [MOVE_W-1:0]         out_move;
  logic                      out_over;

  assign full      = held == CW'(SLOTS);
  assign feed.ready = st == ST_FILL;
  assign feed_fire = feed.valid && feed.ready;
  assign load      = (st == ST_EMIT) && (!out_valid || result.ready);
  assign ctrl      = '{ins: feed_fire && !full, pop: load};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_link_t prev_l;
    cell_link_t next_l;
    if (i == 0) begin : g_first
      assign prev_l = '{value: '0, valid: 1'b1, gt: 1'b0};
    end else begin : g_mid
      assign prev_l = links[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      assign next_l = '{value: '0, valid: 1'b0, gt: 1'b0};
    end else begin : g_inner
      assign next_l = links[i+1];
    end
    isc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (feed.sample_value),
      .prev_link (prev_l),
      .next_link (next_l),
      .link      (links[i])
    );
    assign gt_vec[i] = links[i].gt;
  end

  isc_popcount #(.SLOTS(SLOTS)) u_popcount (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctrl.ins),
    .gt_vec    (gt_vec),
    .busy      (pc_busy),
    .sum_valid (pc_valid),
    .sum       (pc_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ST_FILL;
      held            <= '0;
      compare_counter <= '0;
      drop_flag       <= 1'b0;
    end else begin
      if (pc_valid) begin
        compare_counter <= compare_counter + COUNTER_W'(pc_sum);
      end
      unique case (st)
        ST_FILL: begin
          if (feed_fire) begin
            if (full) begin
              drop_flag <= 1'b1;
            end else begin
              held <= held + CW'(1);
            end
            if (feed.final_item) begin
              st <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (!pc_busy) begin
            st <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            // last word of the set goes out; start the next set
            if (held == CW'(1)) begin
              st              <= ST_FILL;
              held            <= '0;
              compare_counter <= '0;
              drop_flag       <= 1'b0;
            end else begin
              held <= held - CW'(1);
            end
          end
        end
        default: st <= ST_FILL;
      endcase
    end
  end

  // moves are shifts plus one placement per held word
  always_ff @(posedge clk) begin
    if (st == ST_WAIT) begin
      move_hold <= compare_counter + COUNTER_W'(held);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value   <= links[0].value;
      out_final   <= held == CW'(1);
      out_compare <= compare_counter[COMPARE_W-1:0];
      out_move    <= move_hold[MOVE_W-1:0];
      out_over    <= drop_flag;
    end
  end

  assign result.valid         = out_valid;
  assign result.sorted_value  = out_value;
  assign result.final_result  = out_final;
  assign result.compare_total = out_compare;
  assign result.move_total    = out_move;
  assign result.overflowed    = out_over;

endmodule

[rtl/core/isc_checker.sv]
// port-level checks for the insertion sorter, bound to the top level
// depends on isc_pkg and insertion_sorter_with_counts_unit

module isc_checker
  import isc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      feed_valid,
  input logic                      feed_ready,
  input logic                      feed_final,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic signed [VALUE_W-1:0] result_value,
  input logic                      result_final,
  input logic [COMPARE_W-1:0]      result_compare,
  input logic [MOVE_W-1:0]         result_move
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_value))
    else $error("result word changed while stalled");

  // no new word is taken while a set is still being emitted
  a_no_feed_mid_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_final |-> !feed_ready)
    else $error("feed ready during emission");

  // a final word closes the feed for the next cycle
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    feed_valid && feed_ready && feed_final |=> !feed_ready)
    else $error("feed still ready after final word");

  // results of one set follow back to back with the same totals
  a_set_totals: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result_final |=>
      result_valid && $stable(result_compare) && $stable(result_move))
    else $error("set totals changed within a set");

endmodule

bind insertion_sorter_with_counts_unit isc_checker u_isc_checker (
  .clk            (clk),
  .rst            (rst),
  .feed_valid     (feed.valid),
  .feed_ready     (feed.ready),
  .feed_final     (feed.final_item),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_value   (result.sorted_value),
  .result_final   (result.final_result),
  .result_compare (result.compare_total),
  .result_move    (result.move_total)
);
